// File: rtl/kslint_pkg.sv
// Shared types and constants for the k-way sorted list intersection block.
// No dependencies; compile first.
package kslint_pkg;

    localparam int SEL_W     = 3;
    localparam int KEY_IN_W  = 32;
    localparam int MASK_W    = 8;
    localparam int KEY_OUT_W = 32;

    localparam logic [KEY_IN_W-1:0] INVALID_KEY = '0;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_RUN    = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

endpackage

// File: rtl/kslint_if.sv
// Valid/ready channels for the intersection block: command items in, result items out.
// Depends on kslint_pkg.
interface kslint_in_if;
    import kslint_pkg::*;

    logic                valid;
    logic                ready;
    op_t                 op;
    logic [SEL_W-1:0]    list_select;
    logic [KEY_IN_W-1:0] key_value;
    logic [MASK_W-1:0]   active_mask;

    modport source (output valid, op, list_select, key_value, active_mask, input ready);
    modport sink   (input valid, op, list_select, key_value, active_mask, output ready);
endinterface

interface kslint_out_if;
    import kslint_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [KEY_OUT_W-1:0] common_key;
    logic                 found;
    logic                 last;
    logic                 overflow;

    modport source (output valid, common_key, found, last, overflow, input ready);
    modport sink   (input valid, common_key, found, last, overflow, output ready);
endinterface

// File: rtl/kway_sorted_list_intersect.sv
// K-way sorted list intersection. Clear and append items are taken one per cycle while
// no run is in progress and return nothing. A run item holds the request channel until
// its last result item has been placed in the output register. Each step of a run
// re-reads the moved list heads through the single read port of the key memory (a load
// sweep over the LISTS heads, then a drain state), then sweeps the LISTS heads through
// one shared compare unit. Keys are stored in KEY_WIDTH bits; the key memory needs no
// clearing after reset.
// Depends on kslint_pkg and kslint_if.
module kway_sorted_list_intersect #(
    parameter int LISTS      = 8,
    parameter int LIST_DEPTH = 64,
    parameter int KEY_WIDTH  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    kslint_in_if.sink   request,
    kslint_out_if.source result
);
    import kslint_pkg::*;

    localparam int ENTRIES = LISTS * LIST_DEPTH;
    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LW      = (LISTS > 1) ? $clog2(LISTS) : 1;
    localparam int PW      = $clog2(LIST_DEPTH + 1);

    typedef logic [KEY_WIDTH-1:0] key_t;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_LOAD   = 6'b000010,
        ST_DRAIN  = 6'b000100,
        ST_SCAN   = 6'b001000,
        ST_MATCH  = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    function automatic logic [AW-1:0] addr_of(input logic [LW-1:0] l, input logic [PW-1:0] p);
        return AW'(l) * AW'(LIST_DEPTH) + AW'(p);
    endfunction

    key_t mem [ENTRIES];

    state_t            state_reg,       state_next;
    logic [LW-1:0]     idx_reg,         idx_next;
    logic [PW-1:0]     len_reg  [LISTS];
    logic [PW-1:0]     len_next [LISTS];
    logic [PW-1:0]     head_reg [LISTS];
    logic [PW-1:0]     head_next[LISTS];
    key_t              last_key_reg [LISTS];
    key_t              last_key_next[LISTS];
    key_t              cur_key_reg  [LISTS];
    key_t              cur_key_next [LISTS];
    logic [LISTS-1:0]  stale_reg,       stale_next;
    logic [LISTS-1:0]  act_reg,         act_next;
    logic              fetch_valid_reg, fetch_valid_next;
    logic [LW-1:0]     fetch_idx_reg,   fetch_idx_next;
    key_t              rd_data_reg;
    key_t              small_reg,       small_next;
    logic [LW-1:0]     si_reg,          si_next;
    logic              same_reg,        same_next;
    logic              have_reg,        have_next;
    logic              done_reg,        done_next;
    logic              held_have_reg,   held_have_next;
    key_t              held_key_reg,    held_key_next;
    logic              overflow_reg,    overflow_next;
    logic              out_valid_reg,   out_valid_next;
    logic [KEY_OUT_W-1:0] out_key_reg,  out_key_next;
    logic              out_found_reg,   out_found_next;
    logic              out_last_reg,    out_last_next;
    logic              out_ovf_reg,     out_ovf_next;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [AW-1:0]     rd_addr;
    logic [63:0]       key_wide;
    key_t              key_in;
    logic [LW-1:0]     sel;
    logic              sel_ok;
    logic              out_free;
    logic              any_act;
    logic              empty_act;
    key_t              cur;
    logic [PW-1:0]     step;
    logic [63:0]       held_wide;

    assign key_wide  = 64'(request.key_value);
    assign key_in    = key_wide[KEY_WIDTH-1:0];
    assign sel       = request.list_select[LW-1:0];
    assign sel_ok    = {1'b0, request.list_select} < (SEL_W + 1)'(LISTS);
    assign out_free  = !out_valid_reg || result.ready;
    assign held_wide = 64'(held_key_reg);

    assign request.ready     = (state_reg == ST_IDLE);
    assign result.valid      = out_valid_reg;
    assign result.common_key = out_key_reg;
    assign result.found      = out_found_reg;
    assign result.last       = out_last_reg;
    assign result.overflow   = out_ovf_reg;

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        len_next         = len_reg;
        head_next        = head_reg;
        last_key_next    = last_key_reg;
        cur_key_next     = cur_key_reg;
        stale_next       = stale_reg;
        act_next         = act_reg;
        fetch_valid_next = 1'b0;
        fetch_idx_next   = fetch_idx_reg;
        small_next       = small_reg;
        si_next          = si_reg;
        same_next        = same_reg;
        have_next        = have_reg;
        done_next        = done_reg;
        held_have_next   = held_have_reg;
        held_key_next    = held_key_reg;
        overflow_next    = overflow_reg;
        out_valid_next   = out_valid_reg && !result.ready;
        out_key_next     = out_key_reg;
        out_found_next   = out_found_reg;
        out_last_next    = out_last_reg;
        out_ovf_next     = out_ovf_reg;
        mem_we           = 1'b0;
        mem_waddr        = addr_of(sel, len_reg[sel]);
        rd_addr          = addr_of(idx_reg, head_reg[idx_reg]);
        any_act          = 1'b0;
        empty_act        = 1'b0;
        cur              = cur_key_reg[idx_reg];
        step             = '0;

        if (fetch_valid_reg)
        begin
            cur_key_next[fetch_idx_reg] = rd_data_reg;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (request.valid)
                begin
                    unique case (request.op)
                        OP_CLEAR:
                        begin
                            for (int i = 0; i < LISTS; i++)
                            begin
                                len_next[i]  = '0;
                                head_next[i] = '0;
                            end
                        end
                        OP_APPEND:
                        begin
                            if (sel_ok && key_in != KEY_WIDTH'(INVALID_KEY))
                            begin
                                if (len_reg[sel] >= PW'(LIST_DEPTH))
                                begin
                                    overflow_next = 1'b1;
                                end
                                else if (len_reg[sel] == '0 || key_in > last_key_reg[sel])
                                begin
                                    mem_we             = 1'b1;
                                    len_next[sel]      = len_reg[sel] + PW'(1);
                                    last_key_next[sel] = key_in;
                                end
                            end
                        end
                        OP_RUN:
                        begin
                            for (int i = 0; i < LISTS; i++)
                            begin
                                head_next[i] = '0;
                                if (request.active_mask[i])
                                begin
                                    any_act = 1'b1;
                                    if (len_reg[i] == '0)
                                    begin
                                        empty_act = 1'b1;
                                    end
                                end
                            end
                            act_next       = request.active_mask[LISTS-1:0];
                            stale_next     = request.active_mask[LISTS-1:0];
                            held_have_next = 1'b0;
                            idx_next       = '0;
                            state_next     = (any_act && !empty_act) ? ST_LOAD : ST_FINISH;
                        end
                        OP_NOP:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_LOAD:
            begin
                if (stale_reg[idx_reg])
                begin
                    fetch_valid_next    = 1'b1;
                    fetch_idx_next      = idx_reg;
                    stale_next[idx_reg] = 1'b0;
                end
                if (idx_reg == LW'(LISTS - 1))
                begin
                    idx_next   = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + LW'(1);
                end
            end
            ST_DRAIN:
            begin
                idx_next   = '0;
                have_next  = 1'b0;
                same_next  = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (act_reg[idx_reg])
                begin
                    if (!have_reg)
                    begin
                        have_next  = 1'b1;
                        small_next = cur;
                        si_next    = idx_reg;
                    end
                    else if (cur != small_reg)
                    begin
                        same_next = 1'b0;
                        if (cur < small_reg)
                        begin
                            small_next = cur;
                            si_next    = idx_reg;
                        end
                    end
                end
                if (idx_reg == LW'(LISTS - 1))
                begin
                    idx_next  = '0;
                    done_next = 1'b0;
                    if (same_next)
                    begin
                        for (int i = 0; i < LISTS; i++)
                        begin
                            if (act_reg[i])
                            begin
                                head_next[i] = head_reg[i] + PW'(1);
                                if (head_next[i] >= len_reg[i])
                                begin
                                    done_next = 1'b1;
                                end
                            end
                        end
                        stale_next = act_reg;
                        state_next = ST_MATCH;
                    end
                    else
                    begin
                        step                = head_reg[si_next] + PW'(1);
                        head_next[si_next]  = step;
                        stale_next[si_next] = 1'b1;
                        done_next           = (step >= len_reg[si_next]);
                        state_next          = done_next ? ST_FINISH : ST_LOAD;
                    end
                end
                else
                begin
                    idx_next = idx_reg + LW'(1);
                end
            end
            ST_MATCH:
            begin
                if (out_free || !held_have_reg)
                begin
                    if (held_have_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_key_next   = held_wide[KEY_OUT_W-1:0];
                        out_found_next = 1'b1;
                        out_last_next  = 1'b0;
                        out_ovf_next   = overflow_reg;
                    end
                    held_have_next = 1'b1;
                    held_key_next  = small_reg;
                    state_next     = done_reg ? ST_FINISH : ST_LOAD;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_key_next   = held_have_reg ? held_wide[KEY_OUT_W-1:0] : '0;
                    out_found_next = held_have_reg;
                    out_last_next  = 1'b1;
                    out_ovf_next   = overflow_reg;
                    held_have_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            idx_reg         <= '0;
            for (int i = 0; i < LISTS; i++)
            begin
                len_reg[i]  <= '0;
                head_reg[i] <= '0;
            end
            stale_reg       <= '0;
            act_reg         <= '0;
            fetch_valid_reg <= 1'b0;
            fetch_idx_reg   <= '0;
            si_reg          <= '0;
            same_reg        <= 1'b0;
            have_reg        <= 1'b0;
            done_reg        <= 1'b0;
            held_have_reg   <= 1'b0;
            overflow_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_found_reg   <= 1'b0;
            out_last_reg    <= 1'b0;
            out_ovf_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            len_reg         <= len_next;
            head_reg        <= head_next;
            stale_reg       <= stale_next;
            act_reg         <= act_next;
            fetch_valid_reg <= fetch_valid_next;
            fetch_idx_reg   <= fetch_idx_next;
            si_reg          <= si_next;
            same_reg        <= same_next;
            have_reg        <= have_next;
            done_reg        <= done_next;
            held_have_reg   <= held_have_next;
            overflow_reg    <= overflow_next;
            out_valid_reg   <= out_valid_next;
            out_found_reg   <= out_found_next;
            out_last_reg    <= out_last_next;
            out_ovf_reg     <= out_ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_key_reg <= last_key_next;
        cur_key_reg  <= cur_key_next;
        small_reg    <= small_next;
        held_key_reg <= held_key_next;
        out_key_reg  <= out_key_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= key_in;
        end
        rd_data_reg <= mem[rd_addr];
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.found |-> result.last)
        else $error("not-found item is not the last of its run");

    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.found |-> result.common_key == '0)
        else $error("not-found item carries a nonzero key");

    assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |=> overflow_reg)
        else $error("overflow flag dropped without reset");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> (stale_reg & ~act_reg) == '0)
        else $error("head reload pending for an inactive list");
`endif

endmodule

// File: tb/sv/tb_top.sv
// Self-checking bench for kway_sorted_list_intersect: directed list and run items, then random
// list builds with queries, checked against a shadow copy of the lists kept in the bench.
// Depends on kslint_pkg, kslint_in_if/kslint_out_if and the kway_sorted_list_intersect RTL.
module tb_top;
    import kslint_pkg::*;

    localparam int LISTS       = 8;
    localparam int LIST_DEPTH  = 64;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int TAIL_CYCLES = 4 * LISTS + 32;

    typedef struct packed {
        logic [KEY_OUT_W-1:0] key;
        logic                 found;
        logic                 last;
        logic                 ovf;
    } match_t;

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   fail_count;
    bit   no_idle;

    logic [KEY_IN_W-1:0] shadow_keys [LISTS][LIST_DEPTH];
    int                  shadow_len  [LISTS];
    bit                  shadow_ovf;
    match_t              common_key_q [$];
    match_t              want;

    kslint_in_if  request_ch ();
    kslint_out_if result_ch ();

    kway_sorted_list_intersect #(
        .LISTS      (LISTS),
        .LIST_DEPTH (LIST_DEPTH),
        .KEY_WIDTH  (32)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .request(request_ch),
        .result (result_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    function automatic int draw_wait();
        return no_idle ? 0 : int'($urandom_range(0, 13));
    endfunction

    // Shadow lists

    task automatic store_key(input logic [SEL_W-1:0] sel, input logic [KEY_IN_W-1:0] key);
        int len;
        len = shadow_len[sel];
        if (key == INVALID_KEY)
            return;
        if (len >= LIST_DEPTH)
        begin
            shadow_ovf = 1'b1;
            return;
        end
        if (len > 0 && key <= shadow_keys[sel][len-1])
            return;
        shadow_keys[sel][len] = key;
        shadow_len[sel]       = len + 1;
    endtask

    task automatic collect_common_keys(input logic [MASK_W-1:0] mask);
        int                  head [LISTS];
        bit                  any_act;
        bit                  empty_act;
        bit                  have;
        bit                  same;
        bit                  done;
        logic [KEY_IN_W-1:0] least_key;
        logic [KEY_IN_W-1:0] v;
        int                  least_i;
        match_t              run_q [$];
        any_act   = 1'b0;
        empty_act = 1'b0;
        least_key = '0;
        least_i   = 0;
        for (int i = 0; i < LISTS; i++)
        begin
            head[i] = 0;
            if (mask[i])
            begin
                any_act = 1'b1;
                if (shadow_len[i] == 0)
                    empty_act = 1'b1;
            end
        end
        if (any_act && !empty_act)
        begin
            done = 1'b0;
            while (!done)
            begin
                have = 1'b0;
                same = 1'b1;
                for (int i = 0; i < LISTS; i++)
                begin
                    if (mask[i])
                    begin
                        v = shadow_keys[i][head[i]];
                        if (!have)
                        begin
                            have      = 1'b1;
                            least_key = v;
                            least_i   = i;
                        end
                        else if (v != least_key)
                        begin
                            same = 1'b0;
                            if (v < least_key)
                            begin
                                least_key = v;
                                least_i   = i;
                            end
                        end
                    end
                end
                if (same)
                begin
                    run_q.push_back('{key: least_key, found: 1'b1, last: 1'b0, ovf: shadow_ovf});
                    for (int i = 0; i < LISTS; i++)
                    begin
                        if (mask[i])
                        begin
                            head[i]++;
                            if (head[i] >= shadow_len[i])
                                done = 1'b1;
                        end
                    end
                end
                else
                begin
                    head[least_i]++;
                    if (head[least_i] >= shadow_len[least_i])
                        done = 1'b1;
                end
            end
        end
        if (run_q.size() == 0)
            run_q.push_back('{key: '0, found: 1'b0, last: 1'b1, ovf: shadow_ovf});
        else
            run_q[run_q.size()-1].last = 1'b1;
        foreach (run_q[i])
            common_key_q.push_back(run_q[i]);
    endtask

    task automatic track_item(input op_t op, input logic [SEL_W-1:0] sel,
                              input logic [KEY_IN_W-1:0] key, input logic [MASK_W-1:0] mask);
        case (op)
            OP_CLEAR:
                for (int i = 0; i < LISTS; i++)
                    shadow_len[i] = 0;
            OP_APPEND:
                store_key(sel, key);
            OP_RUN:
                collect_common_keys(mask);
            default:
                ;
        endcase
    endtask

    // Request side

    task automatic send_item(input op_t op, input logic [SEL_W-1:0] sel,
                             input logic [KEY_IN_W-1:0] key, input logic [MASK_W-1:0] mask);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            request_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request_ch.op          <= op;
        request_ch.list_select <= sel;
        request_ch.key_value   <= key;
        request_ch.active_mask <= mask;
        request_ch.valid       <= 1'b1;
        // predict on presentation: a run emits its items only after the request is taken
        track_item(op, sel, key, mask);
        do
            @(posedge clk);
        while (!request_ch.ready);
    endtask

    task automatic wait_results_drained();
        request_ch.valid <= 1'b0;
        @(posedge clk);
        while (common_key_q.size() != 0)
            @(posedge clk);
    endtask

    // Result side

    initial
    begin
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            int stall;
            stall = draw_wait();
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(result_ch.valid && result_ch.ready));
        end
    end

    task automatic report_mismatch(input string field, input logic [31:0] exp_v,
                                   input logic [31:0] act_v);
        $display("%0t: %s mismatch, expected %h, actual %h", $realtime, field, exp_v, act_v);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (common_key_q.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual key %h found %b last %b ovf %b",
                         $realtime, result_ch.common_key, result_ch.found, result_ch.last,
                         result_ch.overflow);
                fail_count++;
            end
            else
            begin
                want = common_key_q.pop_front();
                if (result_ch.common_key !== want.key)
                    report_mismatch("common_key", want.key, result_ch.common_key);
                if (result_ch.found !== want.found)
                    report_mismatch("found", 32'(want.found), 32'(result_ch.found));
                if (result_ch.last !== want.last)
                    report_mismatch("last", 32'(want.last), 32'(result_ch.last));
                if (result_ch.overflow !== want.ovf)
                    report_mismatch("overflow", 32'(want.ovf), 32'(result_ch.overflow));
            end
        end
    end

    // Tests

    task automatic test_empty_runs();
        send_item(OP_RUN, '0, '0, 8'h00);
        send_item(OP_RUN, '0, '0, 8'hFF);
    endtask

    task automatic test_key_filtering();
        send_item(OP_APPEND, 3'd0, INVALID_KEY, '0);
        send_item(OP_APPEND, 3'd0, 32'h0000_0001, '0);
        send_item(OP_APPEND, 3'd0, 32'hFFFF_FFFF, '0);
        send_item(OP_APPEND, 3'd0, 32'h0000_0005, '0);
        send_item(OP_APPEND, 3'd0, 32'hFFFF_FFFF, '0);
        send_item(OP_APPEND, 3'd7, 32'h0000_0001, '0);
        send_item(OP_APPEND, 3'd7, 32'h8000_0000, '0);
        send_item(OP_APPEND, 3'd7, 32'hFFFF_FFFF, '0);
        send_item(OP_RUN, '0, '0, 8'h81);
        send_item(OP_RUN, '0, '0, 8'h01);
        send_item(OP_RUN, '0, '0, 8'h83);
    endtask

    task automatic test_clear_and_nop();
        send_item(OP_NOP, 3'd7, 32'hFFFF_FFFF, 8'hFF);
        send_item(OP_RUN, '0, '0, 8'h80);
        send_item(OP_CLEAR, '0, '0, '0);
        send_item(OP_RUN, '0, '0, 8'h80);
        send_item(OP_APPEND, 3'd7, 32'h0000_0002, '0);
        send_item(OP_RUN, '0, '0, 8'h80);
        wait_results_drained();
    endtask

    task automatic send_noise();
        logic [KEY_IN_W-1:0] key;
        case ($urandom_range(0, 2))
            0: key = INVALID_KEY;
            1: key = $urandom_range(1, 60);
            default: key = $urandom;
        endcase
        case ($urandom_range(0, 3))
            0: send_item(OP_NOP, SEL_W'($urandom), key, MASK_W'($urandom));
            1: send_item(OP_RUN, SEL_W'($urandom), key, MASK_W'($urandom));
            default: send_item(OP_APPEND, SEL_W'($urandom), key, MASK_W'($urandom));
        endcase
    endtask

    task automatic build_and_query(input bit full, output int used);
        logic [KEY_IN_W-1:0] pool [$];
        logic [KEY_IN_W-1:0] key;
        logic [SEL_W-1:0]    sel;
        logic [MASK_W-1:0]   filled;
        logic [MASK_W-1:0]   mask;
        int                  pool_n;
        int                  mode;
        int                  nlists;
        int                  nrun;
        used    = 0;
        no_idle = ($urandom_range(0, 3) == 0);
        if (full || $urandom_range(0, 5) != 0)
        begin
            send_item(OP_CLEAR, SEL_W'($urandom), $urandom, MASK_W'($urandom));
            used++;
        end
        pool_n = full ? $urandom_range(66, 70) : $urandom_range(1, 12);
        mode   = full ? 0 : $urandom_range(0, 2);
        for (int i = 0; i < pool_n; i++)
        begin
            case (mode)
                0: key = $urandom;
                1: key = $urandom_range(1, 60);
                default: key = 32'hFFFF_FFFF - $urandom_range(0, 60);
            endcase
            if (key == INVALID_KEY)
                key = 32'h1;
            pool.push_back(key);
        end
        pool.sort();
        filled = '0;
        nlists = full ? 2 : $urandom_range(1, LISTS);
        for (int j = 0; j < nlists; j++)
        begin
            sel         = SEL_W'($urandom);
            filled[sel] = 1'b1;
            for (int i = 0; i < pool_n; i++)
            begin
                if (full || $urandom_range(0, 9) < 7)
                begin
                    send_item(OP_APPEND, sel, pool[i], MASK_W'($urandom));
                    used++;
                end
                if (!full && $urandom_range(0, 11) == 0)
                    send_noise();
            end
        end
        nrun = $urandom_range(1, 3);
        for (int k = 0; k < nrun; k++)
        begin
            if (k == 0 && $urandom_range(0, 3) != 0)
                mask = filled;
            else if ($urandom_range(0, 1) == 0)
                mask = filled & MASK_W'($urandom);
            else
                mask = MASK_W'($urandom);
            send_item(OP_RUN, SEL_W'($urandom), $urandom, mask);
            used++;
        end
        if ($urandom_range(0, 5) == 0)
            wait_results_drained();
    endtask

    task automatic test_random_lists(input int n_items, input bit allow_full);
        int  sent;
        int  used;
        bit  first;
        sent  = 0;
        first = 1'b1;
        while (sent < n_items)
        begin
            build_and_query(allow_full && (first || $urandom_range(0, 9) == 0), used);
            sent  += used;
            first  = 1'b0;
        end
        no_idle = 1'b0;
    endtask

    task automatic finish_run();
        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        cycle_count            = 0;
        fail_count             = 0;
        no_idle                = 1'b0;
        shadow_ovf             = 1'b0;
        request_ch.valid       = 1'b0;
        request_ch.op          = OP_NOP;
        request_ch.list_select = '0;
        request_ch.key_value   = '0;
        request_ch.active_mask = '0;
        for (int i = 0; i < LISTS; i++)
            shadow_len[i] = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_runs();
        test_key_filtering();
        test_clear_and_nop();
        test_random_lists(150, 1'b0);
        wait_results_drained();
        test_random_lists(210, 1'b1);
        finish_run();
    end

endmodule

// File: files.f
rtl/kslint_pkg.sv
rtl/kslint_if.sv
rtl/kway_sorted_list_intersect.sv
tb/sv/tb_top.sv
